/* hdl/execution_latency_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for execution_latency_queue
// Shared property templates, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EXECUTION_LATENCY_QUEUE_ASSERT_SVH
`define EXECUTION_LATENCY_QUEUE_ASSERT_SVH

// same-cycle implication
`define ELQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/elq_pkg.sv */
// ----------------------------------------------------------------------------
// elq_pkg
// Types, constants and helpers shared by the execution latency queue.
// ----------------------------------------------------------------------------
`default_nettype none

package elq_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TAG_W   = 32;
    localparam int CNT_W   = 8;

    localparam logic [CNT_W-1:0] LOAD_LATENCY_RESET = CNT_W'(2);
    localparam logic [CNT_W-1:0] ALU_LATENCY        = CNT_W'(1);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_REMOVED = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic              any_done;
    } result_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
    } pick_t;

    // lowest set bit of a slot vector
    function automatic pick_t lowest_set(input logic [ENTRIES-1:0] vec);
        pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                p.found = 1'b1;
                p.idx   = IDX_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

/* hdl/elq_table.sv */
// ----------------------------------------------------------------------------
// elq_table
// Slot table: valid bits, countdowns and tags; applies one command per step.
// ----------------------------------------------------------------------------
`default_nettype none

module elq_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [1:0]                   cmd,
    input  wire logic                         is_load,
    input  wire logic [elq_pkg::TAG_W-1:0]    inst_tag,
    input  wire logic                         cfg_we,
    input  wire logic [elq_pkg::CNT_W-1:0]    cfg_data,
    output elq_pkg::result_t                  result
);
    import elq_pkg::*;

    logic [CNT_W-1:0]    load_latency_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [CNT_W-1:0]    countdown_reg  [ENTRIES];
    logic [CNT_W-1:0]    countdown_next [ENTRIES];
    logic [TAG_W-1:0]    tag_reg        [ENTRIES];

    logic [ENTRIES-1:0]  free_vec;
    logic [ENTRIES-1:0]  done_vec;
    logic [ENTRIES-1:0]  done_next_vec;
    pick_t               free_pick;
    pick_t               done_pick;
    logic                do_insert;
    logic                do_remove;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            free_vec[i] = !valid_reg[i];
            done_vec[i] = valid_reg[i] && (countdown_reg[i] == '0);
        end
        free_pick = lowest_set(free_vec);
        done_pick = lowest_set(done_vec);

        do_insert = (cmd == CMD_INSERT) && free_pick.found;
        do_remove = (cmd == CMD_REMOVE) && done_pick.found;

        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            countdown_next[i] = countdown_reg[i];
            if ((cmd == CMD_TICK) && valid_reg[i] && (countdown_reg[i] != '0))
            begin
                countdown_next[i] = countdown_reg[i] - CNT_W'(1);
            end
        end
        if (do_insert)
        begin
            valid_next[free_pick.idx]     = 1'b1;
            countdown_next[free_pick.idx] = is_load ? load_latency_reg : ALU_LATENCY;
        end
        if (do_remove)
        begin
            valid_next[done_pick.idx] = 1'b0;
        end

        for (int i = 0; i < ENTRIES; i++)
        begin
            done_next_vec[i] = valid_next[i] && (countdown_next[i] == '0);
        end

        result.any_done = |done_next_vec;
        result.tag      = '0;
        case (cmd)
            CMD_TICK:   result.status = STAT_OK;
            CMD_INSERT: result.status = free_pick.found ? STAT_OK : STAT_FULL;
            CMD_REMOVE:
            begin
                result.status = done_pick.found ? STAT_REMOVED : STAT_EMPTY;
                if (done_pick.found)
                begin
                    result.tag = tag_reg[done_pick.idx];
                end
            end
            default:    result.status = STAT_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_latency_reg <= LOAD_LATENCY_RESET;
            valid_reg        <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                countdown_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                load_latency_reg <= cfg_data;
            end
            if (step)
            begin
                valid_reg <= valid_next;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    countdown_reg[i] <= countdown_next[i];
                end
            end
        end
    end

    // tags only matter while their slot is valid
    always_ff @(posedge clk)
    begin
        if (step && do_insert)
        begin
            tag_reg[free_pick.idx] <= inst_tag;
        end
    end

endmodule

`default_nettype wire

/* hdl/elq_out_reg.sv */
// ----------------------------------------------------------------------------
// elq_out_reg
// Result register with valid flag; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module elq_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire elq_pkg::result_t     result,
    output logic                      can_load,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output elq_pkg::result_t          out_result
);
    import elq_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

/* hdl/execution_latency_queue.sv */
// Results: each result is registered and appears in the cycle after its command transfer.
// Throughput: one command per cycle while the result register is free or draining;
//   the table update and the priority picks over the slots finish in the same cycle as the transfer.
// Reset (rst_n, async, active low): all slots empty, countdowns zero,
//   load latency at LOAD_LATENCY_RESET, no result pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
// execution_latency_queue
// Table of in-flight instructions with per-slot latency countdowns.
// ----------------------------------------------------------------------------
`default_nettype none
`include "execution_latency_queue_assert.svh"

module execution_latency_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // command stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] inst_tag
    input  wire logic [2:0]   s_axis_tuser,   // [1:0] command, [2] is_load
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // [31:0] out_tag, [32] any_done, rest zero
    output logic [1:0]        m_axis_tuser,   // [1:0] status
    // load latency register
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data
);
    import elq_pkg::*;

    logic    step;       // command transfer this cycle
    logic    can_load;   // result register free or draining
    result_t step_result;
    result_t out_result;

    // Register writes are always taken; the user must write only while the block is idle, not enforced here.
    assign cfg_ready     = 1'b1;

    // The next command may enter whenever the result register is empty or
    // being drained in the same cycle.
    assign s_axis_tready = can_load;
    assign step          = s_axis_tvalid && s_axis_tready;

    // Table state and all per-command logic.
    elq_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cmd      (s_axis_tuser[1:0]),
        .is_load  (s_axis_tuser[2]),
        .inst_tag (s_axis_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (step_result)
    );

    // One-deep result register toward the consumer.
    elq_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result     (step_result),
        .can_load   (can_load),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tuser = out_result.status;
    assign m_axis_tdata = {7'b0, out_result.any_done, out_result.tag};

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `ELQ_ASSERT_NEXT(a_result_follows, step, m_axis_tvalid,
        "command transfer did not produce a result")
    `ELQ_ASSERT_NOW(a_tag_only_on_remove,
        m_axis_tvalid && (m_axis_tuser != STAT_REMOVED), m_axis_tdata[31:0] == 32'd0,
        "nonzero tag on a result that is not a removal")
    `ELQ_ASSERT_NOW(a_remove_means_done_or_empty_before,
        m_axis_tvalid && (m_axis_tuser == STAT_EMPTY), !m_axis_tdata[32],
        "remove found nothing yet a finished entry is reported")
    `ELQ_ASSERT_NOW(a_stall_only_when_full,
        !s_axis_tready, m_axis_tvalid && !m_axis_tready,
        "input stalled while the result register can move")

endmodule

`default_nettype wire
